// ===== hdl/lam_pkg.sv =====
package lam_pkg;

  localparam int unsigned DataW           = 32;
  localparam int unsigned FracBitsDefault = 16;
  // Largest magnitude after normalization sits in [2^30, 2^31)
  localparam int unsigned NormW           = 31;
  localparam int unsigned ShiftW          = 5;
  localparam int unsigned SqW             = 2 * NormW;
  localparam int unsigned SumW            = 64;
  localparam int unsigned RootW           = 32;

  typedef logic signed [DataW-1:0] fix_t;

  typedef struct packed {
    fix_t origin_x;
    fix_t origin_y;
    fix_t origin_z;
    fix_t dir_x;
    fix_t dir_y;
    fix_t dir_z;
  } lam_in_t;

  typedef struct packed {
    logic [1:0] row_index;
    fix_t       col0;
    fix_t       col1;
    fix_t       col2;
    fix_t       col3;
    logic       last_row;
    logic       degenerate;
  } lam_out_t;

  // Lane 0 is w (from the direction), lane 1 is u (from the horizontal perpendicular)
  typedef struct packed {
    fix_t [2:0]       org;
    logic             degen;
    logic [1:0][2:0]  neg;
  } lam_side_t;

  typedef struct packed {
    lam_side_t                    side;
    logic [1:0]                   zero;
    logic [1:0][2:0][NormW-1:0]   n;
    logic [1:0][SumW-1:0]         s;
  } lam_sq_t;

  typedef struct packed {
    lam_side_t                    side;
    logic [1:0]                   zero;
    logic [1:0][2:0][NormW-1:0]   n;
    logic [1:0][RootW-1:0]        r;
  } lam_rt_t;

  typedef struct packed {
    fix_t [2:0] org;
    logic       degen;
    fix_t [2:0] w;
    fix_t [2:0] u;
  } lam_basis_t;

  typedef struct packed {
    fix_t [2:0] u;
    fix_t [2:0] v;
    fix_t [2:0] w;
    fix_t [2:0] t;
    logic       degen;
  } lam_mat_t;

endpackage

// ===== hdl/lam_norm.sv =====
module lam_norm
  import lam_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  lam_in_t in_data_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output lam_sq_t out_data_o
);

  localparam int unsigned NumStages = 5;

  function automatic logic [ShiftW-1:0] lead_zeros(input logic [NormW-1:0] x);
    logic [ShiftW-1:0] cnt;
    cnt = '0;
    for (int b = 0; b < NormW; b++) begin
      if (x[b]) cnt = ShiftW'(NormW - 1 - b);
    end
    return cnt;
  endfunction

  function automatic logic [DataW-1:0] mag32(input fix_t x);
    return x[DataW-1] ? (~x + 1'b1) : x;
  endfunction

  logic [NumStages-1:0] valid_q;
  logic                 en;

  lam_side_t                    side_d;
  logic [1:0][2:0][DataW-1:0]   mag_d;
  lam_side_t                    side0_q, side1_q, side2_q, side3_q;
  logic [1:0][2:0][DataW-1:0]   mag0_q, mag1_q;
  logic [1:0]                   rsh_d, rsh1_q, zero_d, zero1_q, zero2_q, zero3_q;
  logic [1:0][ShiftW-1:0]       lsh_d, lsh1_q;
  logic [1:0][2:0][NormW-1:0]   n_d, n2_q, n3_q;
  logic [1:0][2:0][SqW-1:0]     sq_d, sq3_q;
  lam_sq_t                      out_d, out_q;

  assign en          = !valid_q[NumStages-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = valid_q[NumStages-1];
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[NumStages-2:0], in_valid_i};
    end
  end

  // Stage 0: magnitudes and result signs
  always_comb begin
    side_d.org   = {in_data_i.origin_z, in_data_i.origin_y, in_data_i.origin_x};
    side_d.degen = (in_data_i.dir_x == '0) && (in_data_i.dir_y == '0);
    // w = -unit(dir): negative where dir is positive
    side_d.neg[0][0] = !in_data_i.dir_x[DataW-1] && (in_data_i.dir_x != '0);
    side_d.neg[0][1] = !in_data_i.dir_y[DataW-1] && (in_data_i.dir_y != '0);
    side_d.neg[0][2] = !in_data_i.dir_z[DataW-1] && (in_data_i.dir_z != '0);
    // u = unit(dir_y, -dir_x, 0)
    side_d.neg[1][0] = in_data_i.dir_y[DataW-1];
    side_d.neg[1][1] = !in_data_i.dir_x[DataW-1] && (in_data_i.dir_x != '0);
    side_d.neg[1][2] = 1'b0;
    mag_d[0][0] = mag32(in_data_i.dir_x);
    mag_d[0][1] = mag32(in_data_i.dir_y);
    mag_d[0][2] = mag32(in_data_i.dir_z);
    mag_d[1][0] = mag32(in_data_i.dir_y);
    mag_d[1][1] = mag32(in_data_i.dir_x);
    mag_d[1][2] = '0;
  end

  // Stage 1: top bit position of each vector
  always_comb begin
    logic [DataW-1:0] orv;
    for (int l = 0; l < 2; l++) begin
      orv       = mag0_q[l][0] | mag0_q[l][1] | mag0_q[l][2];
      zero_d[l] = (orv == '0);
      rsh_d[l]  = orv[DataW-1];
      lsh_d[l]  = lead_zeros(orv[NormW-1:0]);
    end
  end

  // Stage 2: scale so the largest magnitude lands in [2^30, 2^31)
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      for (int k = 0; k < 3; k++) begin
        n_d[l][k] = rsh1_q[l] ? mag1_q[l][k][DataW-1:1]
                              : (mag1_q[l][k][NormW-1:0] << lsh1_q[l]);
      end
    end
  end

  // Stage 3: squares
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      for (int k = 0; k < 3; k++) begin
        sq_d[l][k] = SqW'(n2_q[l][k]) * SqW'(n2_q[l][k]);
      end
    end
  end

  // Stage 4: sum of squares
  always_comb begin
    out_d.side = side3_q;
    out_d.zero = zero3_q;
    out_d.n    = n3_q;
    for (int l = 0; l < 2; l++) begin
      out_d.s[l] = SumW'(sq3_q[l][0]) + SumW'(sq3_q[l][1]) + SumW'(sq3_q[l][2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side0_q <= side_d;
      mag0_q  <= mag_d;
      side1_q <= side0_q;
      mag1_q  <= mag0_q;
      zero1_q <= zero_d;
      rsh1_q  <= rsh_d;
      lsh1_q  <= lsh_d;
      side2_q <= side1_q;
      zero2_q <= zero1_q;
      n2_q    <= n_d;
      side3_q <= side2_q;
      zero3_q <= zero2_q;
      n3_q    <= n2_q;
      sq3_q   <= sq_d;
      out_q   <= out_d;
    end
  end

endmodule

// ===== hdl/lam_isqrt.sv =====
module lam_isqrt
  import lam_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  lam_sq_t in_data_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output lam_rt_t out_data_o
);

  localparam int unsigned NumStages = RootW;
  localparam int unsigned TrialW    = SumW + 2;

  logic [NumStages-1:0]   valid_q;
  logic                   en;
  lam_sq_t                carry_q [NumStages];
  logic [1:0][SumW-1:0]   rem_q   [NumStages];
  logic [1:0][RootW-1:0]  root_q  [NumStages];

  assign en          = !valid_q[NumStages-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = valid_q[NumStages-1];

  always_comb begin
    out_data_o.side = carry_q[NumStages-1].side;
    out_data_o.zero = carry_q[NumStages-1].zero;
    out_data_o.n    = carry_q[NumStages-1].n;
    out_data_o.r    = root_q[NumStages-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[NumStages-2:0], in_valid_i};
    end
  end

  // One root bit per stage, most significant first
  for (genvar j = 0; j < NumStages; j++) begin : g_stage
    localparam int unsigned BitPos = RootW - 1 - j;
    lam_sq_t               carry_in;
    logic [1:0][SumW-1:0]  rem_in, rem_d;
    logic [1:0][RootW-1:0] root_in, root_d;

    if (j == 0) begin : g_first
      assign carry_in = in_data_i;
      assign rem_in   = in_data_i.s;
      assign root_in  = '0;
    end else begin : g_next
      assign carry_in = carry_q[j-1];
      assign rem_in   = rem_q[j-1];
      assign root_in  = root_q[j-1];
    end

    always_comb begin
      logic [TrialW-1:0] trial;
      for (int l = 0; l < 2; l++) begin
        trial = (TrialW'(root_in[l]) << (BitPos + 1)) | (TrialW'(1) << (2 * BitPos));
        if ({2'b00, rem_in[l]} >= trial) begin
          rem_d[l]  = rem_in[l] - trial[SumW-1:0];
          root_d[l] = root_in[l] | (RootW'(1) << BitPos);
        end else begin
          rem_d[l]  = rem_in[l];
          root_d[l] = root_in[l];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        carry_q[j] <= carry_in;
        rem_q[j]   <= rem_d;
        root_q[j]  <= root_d;
      end
    end
  end

endmodule

// ===== hdl/lam_div.sv =====
module lam_div
  import lam_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FracBitsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  lam_rt_t    in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output lam_basis_t out_data_o
);

  localparam int unsigned QuoW      = FRAC_BITS + 1;
  localparam int unsigned RemW      = NormW + FRAC_BITS + 2;
  localparam int unsigned NumStages = QuoW + 2;

  function automatic fix_t apply_sign(input logic neg, input logic zero,
                                      input logic [QuoW-1:0] quo);
    fix_t mag;
    mag = DataW'(quo);
    if (zero) return '0;
    return neg ? -mag : mag;
  endfunction

  logic [NumStages-1:0]        valid_q;
  logic                        en;
  logic [1:0][2:0][RemW-1:0]   num_d, num_q;
  lam_rt_t                     prep_q;
  lam_rt_t                     carry_q [QuoW];
  logic [1:0][2:0][RemW-1:0]   rem_q   [QuoW];
  logic [1:0][2:0][QuoW-1:0]   quo_q   [QuoW];
  lam_basis_t                  basis_d, basis_q;

  assign en          = !valid_q[NumStages-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = valid_q[NumStages-1];
  assign out_data_o  = basis_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[NumStages-2:0], in_valid_i};
    end
  end

  // Dividend with half the divisor added for rounding
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      for (int k = 0; k < 3; k++) begin
        num_d[l][k] = (RemW'(in_data_i.n[l][k]) << FRAC_BITS) + RemW'(in_data_i.r[l] >> 1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prep_q <= in_data_i;
      num_q  <= num_d;
    end
  end

  // Restoring division, one quotient bit per stage
  for (genvar j = 0; j < QuoW; j++) begin : g_stage
    localparam int unsigned BitPos = FRAC_BITS - j;
    lam_rt_t                   carry_in;
    logic [1:0][2:0][RemW-1:0] rem_in, rem_d;
    logic [1:0][2:0][QuoW-1:0] quo_in, quo_d;

    if (j == 0) begin : g_first
      assign carry_in = prep_q;
      assign rem_in   = num_q;
      assign quo_in   = '0;
    end else begin : g_next
      assign carry_in = carry_q[j-1];
      assign rem_in   = rem_q[j-1];
      assign quo_in   = quo_q[j-1];
    end

    always_comb begin
      logic [RemW-1:0] dsh;
      for (int l = 0; l < 2; l++) begin
        dsh = RemW'(carry_in.r[l]) << BitPos;
        for (int k = 0; k < 3; k++) begin
          if (rem_in[l][k] >= dsh) begin
            rem_d[l][k] = rem_in[l][k] - dsh;
            quo_d[l][k] = quo_in[l][k] | (QuoW'(1) << BitPos);
          end else begin
            rem_d[l][k] = rem_in[l][k];
            quo_d[l][k] = quo_in[l][k];
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        carry_q[j] <= carry_in;
        rem_q[j]   <= rem_d;
        quo_q[j]   <= quo_d;
      end
    end
  end

  // Put signs back; a vector with no length stays zero
  always_comb begin
    basis_d.org   = carry_q[QuoW-1].side.org;
    basis_d.degen = carry_q[QuoW-1].side.degen;
    for (int k = 0; k < 3; k++) begin
      basis_d.w[k] = apply_sign(carry_q[QuoW-1].side.neg[0][k], carry_q[QuoW-1].zero[0],
                                quo_q[QuoW-1][0][k]);
      basis_d.u[k] = apply_sign(carry_q[QuoW-1].side.neg[1][k], carry_q[QuoW-1].zero[1],
                                quo_q[QuoW-1][1][k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      basis_q <= basis_d;
    end
  end

endmodule

// ===== hdl/lam_rows.sv =====
module lam_rows
  import lam_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FracBitsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  lam_basis_t in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output lam_mat_t   out_data_o
);

  localparam int unsigned NumStages = 8;
  localparam int unsigned ProdW     = 2 * DataW;
  localparam int unsigned CrossW    = ProdW + 1;
  localparam int unsigned MagW      = ProdW + 2;
  localparam logic [MagW-1:0] Half     = MagW'(1) << (FRAC_BITS - 1);
  localparam logic [MagW-1:0] PosLimit = (MagW'(1) << (DataW - 1)) - MagW'(1);
  localparam logic [MagW-1:0] NegLimit = MagW'(1) << (DataW - 1);
  localparam fix_t FixMax = {1'b0, {(DataW-1){1'b1}}};
  localparam fix_t FixMin = {1'b1, {(DataW-1){1'b0}}};

  function automatic fix_t sat_fix(input logic neg, input logic [MagW-1:0] q);
    fix_t res;
    if (neg) begin
      res = (q > NegLimit) ? FixMin : fix_t'(-q[DataW-1:0]);
    end else begin
      res = (q > PosLimit) ? FixMax : fix_t'(q[DataW-1:0]);
    end
    return res;
  endfunction

  logic [NumStages-1:0] valid_q;
  logic                 en;

  lam_basis_t                       b0_q, b1_q, b2_q, b3_q;
  logic signed [5:0][ProdW-1:0]     cp_d, cp_q;
  logic signed [2:0][CrossW-1:0]    cr_d, cr_q;
  logic [2:0]                       cneg_q;
  logic [2:0][MagW-1:0]             cmag_d, cmag_q;
  fix_t [2:0]                       v_d, v_q;
  lam_mat_t                         m4_d, m4_q, m5_q, m6_q, out_q;
  logic signed [2:0][2:0][ProdW-1:0] dp_d, dp_q;
  logic signed [2:0][MagW-1:0]      ds_d, ds_q;
  logic [2:0]                       dneg_q;
  logic [2:0][MagW-1:0]             dmag_d, dmag_q;
  fix_t [2:0]                       t_d;

  assign en          = !valid_q[NumStages-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = valid_q[NumStages-1];
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[NumStages-2:0], in_valid_i};
    end
  end

  // v = w x u: partial products
  always_comb begin
    cp_d[0] = $signed(in_data_i.w[1]) * $signed(in_data_i.u[2]);
    cp_d[1] = $signed(in_data_i.w[2]) * $signed(in_data_i.u[1]);
    cp_d[2] = $signed(in_data_i.w[2]) * $signed(in_data_i.u[0]);
    cp_d[3] = $signed(in_data_i.w[0]) * $signed(in_data_i.u[2]);
    cp_d[4] = $signed(in_data_i.w[0]) * $signed(in_data_i.u[1]);
    cp_d[5] = $signed(in_data_i.w[1]) * $signed(in_data_i.u[0]);
  end

  // Element selects come back unsigned: sign-extend the products explicitly
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cr_d[k] = CrossW'($signed(cp_q[2*k])) - CrossW'($signed(cp_q[2*k+1]));
    end
  end

  // Round half away from zero: magnitude plus half, then shift
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cmag_d[k] = (cr_q[k][CrossW-1] ? MagW'(-$signed(cr_q[k])) : MagW'(cr_q[k])) + Half;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      v_d[k] = sat_fix(cneg_q[k], cmag_q[k] >> FRAC_BITS);
    end
  end

  // Translation: dot of each row with the origin
  always_comb begin
    m4_d.u     = b3_q.u;
    m4_d.v     = v_q;
    m4_d.w     = b3_q.w;
    m4_d.t     = '0;
    m4_d.degen = b3_q.degen;
    for (int k = 0; k < 3; k++) begin
      dp_d[0][k] = $signed(b3_q.u[k]) * $signed(b3_q.org[k]);
      dp_d[1][k] = $signed(v_q[k]) * $signed(b3_q.org[k]);
      dp_d[2][k] = $signed(b3_q.w[k]) * $signed(b3_q.org[k]);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ds_d[i] = MagW'($signed(dp_q[i][0])) + MagW'($signed(dp_q[i][1]))
              + MagW'($signed(dp_q[i][2]));
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dmag_d[i] = (ds_q[i][MagW-1] ? MagW'(-ds_q[i]) : MagW'(ds_q[i])) + Half;
    end
  end

  // Negated dot: negative when the dot is positive
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t_d[i] = sat_fix(!dneg_q[i], dmag_q[i] >> FRAC_BITS);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b0_q   <= in_data_i;
      cp_q   <= cp_d;
      b1_q   <= b0_q;
      cr_q   <= cr_d;
      b2_q   <= b1_q;
      for (int k = 0; k < 3; k++) begin
        cneg_q[k] <= cr_q[k][CrossW-1];
        dneg_q[k] <= ds_q[k][MagW-1];
      end
      cmag_q <= cmag_d;
      b3_q   <= b2_q;
      v_q    <= v_d;
      m4_q   <= m4_d;
      dp_q   <= dp_d;
      m5_q   <= m4_q;
      ds_q   <= ds_d;
      m6_q   <= m5_q;
      dmag_q <= dmag_d;
      out_q  <= '{u: m6_q.u, v: m6_q.v, w: m6_q.w, t: t_d, degen: m6_q.degen};
    end
  end

endmodule

// ===== hdl/look_at_view_matrix.sv =====
// World-to-camera matrix for a z-up world, in signed fixed point.
// Input channel (in_valid_i/in_ready_o/in_data_i): one transaction carries a
// camera position and a viewing direction of any length.
// Output channel (out_valid_o/out_ready_i/out_data_o): each input transaction
// yields four output transactions, rows 0 to 3 in order; row 3 is 0 0 0 1 and
// carries last_row. degenerate is set on all four rows when dir_x and dir_y
// are both zero.
// Rows 1 to 3 follow row 0 in order, each once the row before it is taken.
// Pipeline: 5 normalize stages, 32 square-root stages (one root bit each),
// FRAC_BITS + 3 divider stages (one quotient bit each), 8 cross/dot stages and
// a row register that emits one row per cycle while the receiver is ready.
// The four rows each item needs on the single output channel bound the item
// rate; the pipeline takes a new item in any cycle in which its last stage
// can move on.
// Reset empties every stage. When the receiver stalls, the current row holds
// and the pipeline fills up behind it; in_ready_o drops once it is full.
module look_at_view_matrix
  import lam_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FracBitsDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  lam_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output lam_out_t out_data_o
);

  typedef enum logic [1:0] {
    RowU,
    RowV,
    RowW,
    RowH
  } row_e;

  localparam fix_t OneFix = fix_t'(DataW'(1) << FRAC_BITS);

  logic       sq_valid, sq_ready;
  lam_sq_t    sq_data;
  logic       rt_valid, rt_ready;
  lam_rt_t    rt_data;
  logic       basis_valid, basis_ready;
  lam_basis_t basis_data;
  logic       mat_valid, mat_ready;
  lam_mat_t   mat_data;

  row_e       row_q;
  logic       busy_q;
  lam_mat_t   mat_q;
  logic       load;

  lam_norm u_norm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (sq_valid),
    .out_ready_i (sq_ready),
    .out_data_o  (sq_data)
  );

  lam_isqrt u_isqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sq_valid),
    .in_ready_o  (sq_ready),
    .in_data_i   (sq_data),
    .out_valid_o (rt_valid),
    .out_ready_i (rt_ready),
    .out_data_o  (rt_data)
  );

  lam_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rt_valid),
    .in_ready_o  (rt_ready),
    .in_data_i   (rt_data),
    .out_valid_o (basis_valid),
    .out_ready_i (basis_ready),
    .out_data_o  (basis_data)
  );

  lam_rows #(
    .FRAC_BITS (FRAC_BITS)
  ) u_rows (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (basis_valid),
    .in_ready_o  (basis_ready),
    .in_data_i   (basis_data),
    .out_valid_o (mat_valid),
    .out_ready_i (mat_ready),
    .out_data_o  (mat_data)
  );

  // Take the next matrix when idle or while the last row leaves
  assign mat_ready = !busy_q || (out_ready_i && (row_q == RowH));
  assign load      = mat_valid && mat_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      row_q  <= RowU;
    end else if (load) begin
      busy_q <= 1'b1;
      row_q  <= RowU;
    end else if (busy_q && out_ready_i) begin
      if (row_q == RowH) begin
        busy_q <= 1'b0;
      end else begin
        row_q <= row_e'(row_q + 2'd1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      mat_q <= mat_data;
    end
  end

  assign out_valid_o = busy_q;

  always_comb begin
    out_data_o.row_index  = row_q;
    out_data_o.last_row   = (row_q == RowH);
    out_data_o.degenerate = mat_q.degen;
    unique case (row_q)
      RowU: begin
        out_data_o.col0 = mat_q.u[0];
        out_data_o.col1 = mat_q.u[1];
        out_data_o.col2 = mat_q.u[2];
        out_data_o.col3 = mat_q.t[0];
      end
      RowV: begin
        out_data_o.col0 = mat_q.v[0];
        out_data_o.col1 = mat_q.v[1];
        out_data_o.col2 = mat_q.v[2];
        out_data_o.col3 = mat_q.t[1];
      end
      RowW: begin
        out_data_o.col0 = mat_q.w[0];
        out_data_o.col1 = mat_q.w[1];
        out_data_o.col2 = mat_q.w[2];
        out_data_o.col3 = mat_q.t[2];
      end
      RowH: begin
        out_data_o.col0 = '0;
        out_data_o.col1 = '0;
        out_data_o.col2 = '0;
        out_data_o.col3 = OneFix;
      end
      default: begin
        out_data_o.col0 = '0;
        out_data_o.col1 = '0;
        out_data_o.col2 = '0;
        out_data_o.col3 = '0;
      end
    endcase
  end

endmodule

// ===== sim/look_at_view_matrix_test.sv =====
module look_at_view_matrix_test
  import lam_pkg::*;
;

  localparam int FracBits   = FracBitsDefault;
  localparam int CycleLimit = 400000;
  localparam int NumRandom  = 320;

  typedef longint vec3_t [3];

  function automatic longint clamp32(longint x);
    if (x > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
    if (x < -64'sh8000_0000) return -64'sh8000_0000;
    return x;
  endfunction

  function automatic longint shift_round(longint x);
    longint unsigned m;
    m = (x < 0) ? -x : x;
    m = (m + (64'd1 << (FracBits - 1))) >> FracBits;
    return (x < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Bring the largest magnitude into [2^30, 2^31), then divide by the rounded-down length.
  function automatic void normalize(input vec3_t a, output vec3_t o);
    longint unsigned m [3];
    longint unsigned big, s, r, q;
    big = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (a[i] < 0) ? -a[i] : a[i];
      if (m[i] > big) big = m[i];
    end
    if (big == 0) begin
      for (int i = 0; i < 3; i++) o[i] = 0;
      return;
    end
    while (big >= 64'h8000_0000) begin
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
      big = big >> 1;
    end
    while (big < 64'h4000_0000) begin
      for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
      big = big << 1;
    end
    s = 0;
    for (int i = 0; i < 3; i++) s = s + m[i] * m[i];
    r = int_sqrt(s);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << FracBits) + (r >> 1)) / r;
      o[i] = (a[i] < 0) ? -longint'(q) : longint'(q);
    end
  endfunction

  class matrix_scoreboard;
    lam_out_t rows_q[$];
    int       mismatches;
    int       rows_checked;
    int       degen_items;

    function void note_camera(lam_in_t c);
      vec3_t  org, dir, w, u, v, perp;
      longint basis [3][3];
      longint dot;
      logic   degen;
      lam_out_t r;
      org[0] = longint'(c.origin_x);
      org[1] = longint'(c.origin_y);
      org[2] = longint'(c.origin_z);
      dir[0] = longint'(c.dir_x);
      dir[1] = longint'(c.dir_y);
      dir[2] = longint'(c.dir_z);
      degen = (dir[0] == 0) && (dir[1] == 0);
      if (degen) degen_items++;
      normalize(dir, w);
      for (int i = 0; i < 3; i++) w[i] = -w[i];
      perp[0] = dir[1]; perp[1] = -dir[0]; perp[2] = 0;
      normalize(perp, u);
      v[0] = shift_round(w[1] * u[2] - w[2] * u[1]);
      v[1] = shift_round(w[2] * u[0] - w[0] * u[2]);
      v[2] = shift_round(w[0] * u[1] - w[1] * u[0]);
      for (int k = 0; k < 3; k++) begin
        basis[0][k] = clamp32(u[k]);
        basis[1][k] = clamp32(v[k]);
        basis[2][k] = clamp32(w[k]);
      end
      for (int i = 0; i < 3; i++) begin
        dot = 0;
        for (int k = 0; k < 3; k++) dot += basis[i][k] * org[k];
        r.row_index  = 2'(i);
        r.col0       = fix_t'(basis[i][0]);
        r.col1       = fix_t'(basis[i][1]);
        r.col2       = fix_t'(basis[i][2]);
        r.col3       = fix_t'(clamp32(-shift_round(dot)));
        r.last_row   = 1'b0;
        r.degenerate = degen;
        rows_q.push_back(r);
      end
      r.row_index  = 2'd3;
      r.col0       = '0;
      r.col1       = '0;
      r.col2       = '0;
      r.col3       = 32'sd1 <<< FracBits;
      r.last_row   = 1'b1;
      r.degenerate = degen;
      rows_q.push_back(r);
    endfunction

    function void check_row(lam_out_t got);
      lam_out_t exp_row;
      if (rows_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected row: %p", got);
        return;
      end
      exp_row = rows_q.pop_front();
      rows_checked++;
      if (got.row_index != exp_row.row_index || got.col0 != exp_row.col0 ||
          got.col1 != exp_row.col1 || got.col2 != exp_row.col2 ||
          got.col3 != exp_row.col3 || got.last_row != exp_row.last_row ||
          got.degenerate != exp_row.degenerate) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("row mismatch:");
          $display("  expected %p", exp_row);
          $display("  actual   %p", got);
        end
      end
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  lam_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  lam_out_t out_data;
  bit       quiet = 1'b0;
  int       cycles = 0;
  int       items_sent = 0;
  matrix_scoreboard sb = new();

  look_at_view_matrix u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
    if (rst_n && out_valid && out_ready) sb.check_row(out_data);
  end

  // Receiver: stall in random bursts, none in the quiet tail.
  initial begin
    int hold;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 12);
        out_ready <= 1'b0;
        repeat (hold - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offer one camera at a falling edge and hold until the transaction is taken.
  task automatic send_camera(lam_in_t c);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= c;
    do @(posedge clk); while (!in_ready);
    sb.note_camera(c);
    items_sent++;
    @(negedge clk);
  endtask

  function automatic fix_t pick_value(int mode);
    case (mode)
      0: return $urandom();
      1: return $signed($urandom_range(0, 32'h001F_FFFF)) - 32'sh0010_0000;
      2: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000;
    endcase
  endfunction

  task automatic send_dir(fix_t ox, fix_t oy, fix_t oz, fix_t dx, fix_t dy, fix_t dz);
    lam_in_t c;
    c = '{ox, oy, oz, dx, dy, dz};
    send_camera(c);
  endtask

  initial begin
    lam_in_t c;
    int mode;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // zero direction and directions along z
    send_dir(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 0, 0, 0);
    send_dir(32'sh0001_0000, -32'sh0005_0000, 32'sh0007_0000, 0, 0, 32'sh0001_0000);
    send_dir(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0, -32'sh0000_0001);
    send_dir(0, 0, 0, 0, 0, 32'sh8000_0000);
    // axis directions
    send_dir(0, 0, 0, 32'sh0001_0000, 0, 0);
    send_dir(32'sh0000_8000, 0, 0, 0, -32'sh0001_0000, 0);
    send_dir(0, 0, 0, 1, 0, 0);
    send_dir(0, 0, 0, 0, 1, 0);
    // field extremes, saturation of the translation
    send_dir(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
             32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_dir(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
             32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_dir(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
             32'sh8000_0000, 32'sh7FFF_FFFF, 0);
    send_dir(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
             -1, 1, -1);
    send_dir(32'sh0010_0000, -32'sh0020_0000, 32'sh0005_0000,
             32'sh0003_0000, 32'sh0004_0000, -32'sh0002_0000);
    send_dir(-1, -1, -1, -1, -1, 32'sh7FFF_FFFF);
    send_dir(1, 1, 1, 32'sh8000_0000, 0, 32'sh7FFF_FFFF);
    send_dir(0, 0, 0, 32'sh0000_0001, 32'sh7FFF_FFFF, 32'sh8000_0000);

    for (int n = 0; n < NumRandom; n++) begin
      if (n == NumRandom - 40) quiet = 1'b1;
      mode = $urandom_range(0, 3);
      c.origin_x = pick_value(mode);
      c.origin_y = pick_value(mode);
      c.origin_z = pick_value(mode);
      mode = $urandom_range(0, 3);
      c.dir_x = pick_value(mode);
      c.dir_y = pick_value(mode);
      c.dir_z = pick_value(mode);
      // hit the degenerate path now and then with random content
      if ($urandom_range(0, 9) == 0) begin
        c.dir_x = 0;
        c.dir_y = 0;
      end
      send_camera(c);
    end
    in_valid <= 1'b0;

    while (sb.rows_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d camera items (%0d degenerate), checked %0d matrix rows.",
             items_sent, sb.degen_items, sb.rows_checked);
    $display("Mismatches: %0d", sb.mismatches);
    if (sb.mismatches == 0 && sb.rows_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
